FILE: sv/thruster_force_allocation_core_defines.svh
// ----------------------------------------------------------------------------
// Thruster force allocation assertion macros
// Immediate-implication and next-cycle-implication checks on clk, off in rst.
// ----------------------------------------------------------------------------
`ifndef THRUSTER_FORCE_ALLOCATION_CORE_DEFINES_SVH
`define THRUSTER_FORCE_ALLOCATION_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define TFA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define TFA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define TFA_ASSERT_IMP(lbl, ante, cons, msg)
`define TFA_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

FILE: sv/tfa_pkg.sv
// ----------------------------------------------------------------------------
// Thruster force allocation package
// Widths, register and opcode codes, and control structs shared by the core.
// ----------------------------------------------------------------------------
package tfa_pkg;

  localparam int AXES          = 6;
  localparam int AXIS_W        = 3;
  localparam int THR_W         = 3;
  localparam int VALUE_W       = 16;
  localparam int COEF_W        = 24;
  localparam int MASK_W        = 8;
  localparam int OUT_W         = 48;
  localparam int S_W           = VALUE_W + 1;
  localparam int Q_W           = 32;
  localparam int PROD_W        = COEF_W + Q_W;
  localparam int F_SHIFT       = 16;
  localparam int F_W           = PROD_W - F_SHIFT;
  localparam int CPROD_W       = F_W + VALUE_W;
  localparam int C_SHIFT       = 12;
  localparam int C_W           = CPROD_W - C_SHIFT;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = COEF_W;
  localparam int DEF_THRUSTERS = 8;

  localparam logic [AXIS_W-1:0] AXIS_SURGE = AXIS_W'(0);
  localparam logic [AXIS_W-1:0] AXIS_SWAY  = AXIS_W'(1);
  localparam logic [AXIS_W-1:0] AXIS_HEAVE = AXIS_W'(2);
  localparam logic [AXIS_W-1:0] AXIS_ROLL  = AXIS_W'(3);
  localparam logic [AXIS_W-1:0] AXIS_PITCH = AXIS_W'(4);
  localparam logic [AXIS_W-1:0] AXIS_YAW   = AXIS_W'(5);
  localparam logic [AXIS_W-1:0] LAST_AXIS  = AXIS_W'(AXES - 1);

  localparam logic [OUT_W-1:0] SAT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic [OUT_W-1:0] SAT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

  typedef enum logic [0:0] {
    OP_LOAD   = 1'b0,
    OP_SAMPLE = 1'b1
  } opcode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SURGE_POS   = 3'd0,
    REG_SURGE_NEG   = 3'd1,
    REG_LATERAL_POS = 3'd2,
    REG_LATERAL_NEG = 3'd3,
    REG_SURGE_MASK  = 3'd4,
    REG_INVERT_MASK = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic              start;
    logic [S_W-1:0]    s;
    logic [COEF_W-1:0] coef;
  } force_req_t;

  typedef struct packed {
    logic               load;
    logic [AXIS_W-1:0]  load_axis;
    logic [VALUE_W-1:0] load_data;
    logic [THR_W-1:0]   col;
    logic               issue;
    logic [AXIS_W-1:0]  k;
    logic               active;
    logic               clear;
  } acc_cmd_t;

endpackage

FILE: sv/tfa_in_if.sv
// ----------------------------------------------------------------------------
// Sample channel
// Load and speed-sample requests into the allocation core.
// ----------------------------------------------------------------------------
interface tfa_in_if;
  import tfa_pkg::*;

  logic                      valid;
  logic                      ready;
  logic                      opcode;
  logic [THR_W-1:0]          thruster;
  logic [AXIS_W-1:0]         axis;
  logic signed [VALUE_W-1:0] value;
  logic                      last;

  modport source (output valid, opcode, thruster, axis, value, last, input ready);
  modport sink (input valid, opcode, thruster, axis, value, last, output ready);
endinterface

FILE: sv/tfa_out_if.sv
// ----------------------------------------------------------------------------
// Force channel
// Net forces and torques of one thruster set, Q32.16 saturated.
// ----------------------------------------------------------------------------
interface tfa_out_if;
  import tfa_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] surge;
  logic signed [OUT_W-1:0] sway;
  logic signed [OUT_W-1:0] heave;
  logic signed [OUT_W-1:0] roll;
  logic signed [OUT_W-1:0] pitch;
  logic signed [OUT_W-1:0] yaw;

  modport source (output valid, surge, sway, heave, roll, pitch, yaw, input ready);
  modport sink (input valid, surge, sway, heave, roll, pitch, yaw, output ready);
endinterface

FILE: sv/tfa_cfg_if.sv
// ----------------------------------------------------------------------------
// Configuration channel
// Register write requests: index and data.
// ----------------------------------------------------------------------------
interface tfa_cfg_if;
  import tfa_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: sv/tfa_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module tfa_ram #(
  parameter int WIDTH = tfa_pkg::VALUE_W,
  parameter int DEPTH = tfa_pkg::AXES,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: sv/tfa_force.sv
// ----------------------------------------------------------------------------
// Thrust force unit
// Three-stage chain: |s|*s, coefficient product, round to Q.16.
// ----------------------------------------------------------------------------
module tfa_force (
  input  logic                          clk,
  input  logic                          rst,
  input  tfa_pkg::force_req_t           req,
  output logic                          f_valid,
  output logic signed [tfa_pkg::F_W-1:0] f
);
  import tfa_pkg::*;

  logic                     v1, v2, v3;
  logic signed [S_W-1:0]    s_r;
  logic signed [S_W-1:0]    neg_s;
  logic [S_W-2:0]           mag;
  logic signed [COEF_W-1:0] coef_r;
  logic signed [2*S_W-1:0]  q_full;
  logic signed [Q_W-1:0]    q_r;
  logic signed [PROD_W-1:0] prod_full;
  logic signed [PROD_W-1:0] prod_r;
  logic [PROD_W-1:0]        rnd;

  assign neg_s     = -s_r;
  assign mag       = s_r[S_W-1] ? neg_s[S_W-2:0] : s_r[S_W-2:0];
  assign q_full    = $signed({1'b0, mag}) * s_r;
  assign prod_full = coef_r * q_r;
  assign rnd       = prod_r + (PROD_W'(1) << (F_SHIFT - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      v1      <= 1'b0;
      v2      <= 1'b0;
      v3      <= 1'b0;
      f_valid <= 1'b0;
    end else begin
      v1      <= req.start;
      v2      <= v1;
      v3      <= v2;
      f_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      s_r    <= $signed(req.s);
      coef_r <= $signed(req.coef);
    end
    if (v1) begin
      q_r <= q_full[Q_W-1:0];
    end
    if (v2) begin
      prod_r <= prod_full;
    end
    if (v3) begin
      f <= $signed(rnd[PROD_W-1:F_SHIFT]);
    end
  end

endmodule

FILE: sv/tfa_accum.sv
// ----------------------------------------------------------------------------
// Allocation accumulator
// Matrix and axis-sum memories; per-axis read, multiply, round, saturating
// add and write-back, one axis issued per cycle.
// ----------------------------------------------------------------------------
`include "thruster_force_allocation_core_defines.svh"

module tfa_accum #(
  parameter int THRUSTERS = tfa_pkg::DEF_THRUSTERS
) (
  input  logic                            clk,
  input  logic                            rst,
  input  tfa_pkg::acc_cmd_t               cmd,
  input  logic signed [tfa_pkg::F_W-1:0]  f,
  output logic                            done,
  output logic signed [tfa_pkg::OUT_W-1:0] sums [tfa_pkg::AXES]
);
  import tfa_pkg::*;

  localparam int TIDX_W    = (THRUSTERS > 1) ? $clog2(THRUSTERS) : 1;
  localparam int MAT_DEPTH = AXES << TIDX_W;
  localparam int MAT_AW    = AXIS_W + TIDX_W;

  logic [TIDX_W-1:0]         col_idx;
  logic [MAT_AW-1:0]         rd_addr;
  logic [MAT_AW-1:0]         wr_addr;
  logic [VALUE_W-1:0]        mat_rdata;
  logic [OUT_W-1:0]          sum_rdata;
  logic [MAT_DEPTH-1:0]      mat_vld;
  logic [AXES-1:0]           sum_vld;

  logic                      m_valid;
  logic                      m_active;
  logic [AXIS_W-1:0]         m_k;
  logic [MAT_AW-1:0]         m_addr;
  logic                      a_valid;
  logic [AXIS_W-1:0]         a_k;
  logic signed [CPROD_W-1:0] cprod;
  logic signed [OUT_W-1:0]   sum_hold;

  logic signed [VALUE_W-1:0] mval;
  logic signed [OUT_W-1:0]   sval;
  logic signed [CPROD_W-1:0] cprod_full;
  logic [CPROD_W-1:0]        rnd;
  logic signed [C_W-1:0]     c;
  logic [OUT_W:0]            sum_ext;
  logic [OUT_W-1:0]          sat;

  assign col_idx = TIDX_W'(cmd.col);
  assign rd_addr = {cmd.k, col_idx};
  assign wr_addr = {cmd.load_axis, col_idx};

  tfa_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (MAT_DEPTH)
  ) u_matrix (
    .clk   (clk),
    .we    (cmd.load),
    .waddr (wr_addr),
    .wdata (cmd.load_data),
    .re    (cmd.issue),
    .raddr (rd_addr),
    .rdata (mat_rdata)
  );

  tfa_ram #(
    .WIDTH (OUT_W),
    .DEPTH (AXES)
  ) u_sums (
    .clk   (clk),
    .we    (a_valid),
    .waddr (a_k),
    .wdata (sat),
    .re    (cmd.issue),
    .raddr (cmd.k),
    .rdata (sum_rdata)
  );

  // entries never written read as zero
  assign mval       = (m_active && mat_vld[m_addr]) ? $signed(mat_rdata) : '0;
  assign sval       = sum_vld[m_k] ? $signed(sum_rdata) : '0;
  assign cprod_full = f * mval;

  assign rnd     = cprod + (CPROD_W'(1) << (C_SHIFT - 1));
  assign c       = $signed(rnd[CPROD_W-1:C_SHIFT]);
  assign sum_ext = {sum_hold[OUT_W-1], sum_hold} + (OUT_W+1)'(c);
  assign sat     = (sum_ext[OUT_W] != sum_ext[OUT_W-1]) ?
                   (sum_ext[OUT_W] ? SAT_MIN : SAT_MAX) : sum_ext[OUT_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
      a_valid <= 1'b0;
      done    <= 1'b0;
      mat_vld <= '0;
      sum_vld <= '0;
    end else begin
      m_valid <= cmd.issue;
      a_valid <= m_valid;
      // high once all six sums registers hold the new values
      done    <= a_valid && (a_k == LAST_AXIS);
      if (cmd.load) begin
        mat_vld[wr_addr] <= 1'b1;
      end
      if (a_valid) begin
        sum_vld[a_k] <= 1'b1;
      end
      if (cmd.clear) begin
        sum_vld <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    m_k      <= cmd.k;
    m_addr   <= rd_addr;
    m_active <= cmd.active;
    a_k      <= m_k;
    cprod    <= cprod_full;
    sum_hold <= sval;
    if (a_valid) begin
      sums[a_k] <= $signed(sat);
    end
  end

  `TFA_ASSERT_IMP(a_load_quiet, cmd.load, !cmd.issue && !m_valid && !a_valid, "load during accumulation")
  `TFA_ASSERT_IMP(a_clear_final, cmd.clear, done && !a_valid, "clear without final write")
  `TFA_ASSERT_IMP(a_issue_axis, cmd.issue, cmd.k <= LAST_AXIS, "axis counter out of range")

endmodule

FILE: sv/thruster_force_allocation_core.sv
// ----------------------------------------------------------------------------
// Thruster force allocation core
// A matrix load is written straight into the matrix memory while idle. A speed
// sample occupies the block from acceptance through the force chain (sign and
// coefficient select, |s|*s, coefficient product, rounding), the handover, six
// axis passes issued one per cycle through the read-modify-write pipeline of
// the axis-sum memory, and its drain. On a sample marked last the accumulators
// clear and the six sums move to the output register once it is free; the
// register holds the result until it is taken while the next set accumulates.
// ----------------------------------------------------------------------------
`include "thruster_force_allocation_core_defines.svh"

module thruster_force_allocation_core #(
  parameter int THRUSTERS = tfa_pkg::DEF_THRUSTERS
) (
  input logic       clk,
  input logic       rst,
  tfa_in_if.sink    samples,
  tfa_out_if.source forces,
  tfa_cfg_if.sink   cfg
);
  import tfa_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FORCE,
    ST_ACCUM,
    ST_DRAIN,
    ST_EMIT
  } state_t;

  state_t                   state;
  logic [AXIS_W-1:0]        k;
  logic [THR_W-1:0]         t_q;
  logic                     last_q;
  logic                     active_q;
  logic                     out_valid;
  logic signed [OUT_W-1:0]  out_q [AXES];

  logic signed [COEF_W-1:0] surge_pos_coef;
  logic signed [COEF_W-1:0] surge_neg_coef;
  logic signed [COEF_W-1:0] lateral_pos_coef;
  logic signed [COEF_W-1:0] lateral_neg_coef;
  logic [MASK_W-1:0]        surge_class_mask;
  logic [MASK_W-1:0]        invert_mask;

  logic                     in_acc;
  logic                     smp_acc;
  logic                     thr_ok;
  logic                     axis_ok;
  logic signed [S_W-1:0]    v_ext;
  logic signed [S_W-1:0]    s_in;
  logic                     s_pos;
  logic                     slot_free;
  logic                     emit_now;

  force_req_t               freq;
  logic                     f_valid;
  logic signed [F_W-1:0]    f;
  acc_cmd_t                 cmd;
  logic                     acc_done;
  logic signed [OUT_W-1:0]  sums [AXES];

  assign samples.ready = (state == ST_IDLE);
  assign cfg.ready     = 1'b1;

  assign in_acc  = samples.valid && samples.ready;
  assign smp_acc = in_acc && (samples.opcode == OP_SAMPLE);
  assign thr_ok  = int'(samples.thruster) < THRUSTERS;
  assign axis_ok = samples.axis <= LAST_AXIS;

  assign v_ext = S_W'(samples.value);
  assign s_in  = invert_mask[samples.thruster] ? -v_ext : v_ext;
  assign s_pos = !s_in[S_W-1] && (s_in != '0);

  always_comb begin
    freq.start = smp_acc;
    freq.s     = s_in;
    if (surge_class_mask[samples.thruster]) begin
      freq.coef = s_pos ? surge_pos_coef : surge_neg_coef;
    end else begin
      freq.coef = s_pos ? lateral_pos_coef : lateral_neg_coef;
    end
  end

  assign slot_free = !out_valid || forces.ready;
  assign emit_now  = ((state == ST_DRAIN) && acc_done && last_q && slot_free) ||
                     ((state == ST_EMIT) && slot_free);

  always_comb begin
    cmd.load      = in_acc && (samples.opcode == OP_LOAD) && thr_ok && axis_ok;
    cmd.load_axis = samples.axis;
    cmd.load_data = samples.value;
    cmd.col       = (state == ST_IDLE) ? samples.thruster : t_q;
    cmd.issue     = (state == ST_ACCUM);
    cmd.k         = k;
    cmd.active    = active_q;
    cmd.clear     = (state == ST_DRAIN) && acc_done && last_q;
  end

  tfa_force u_force (
    .clk     (clk),
    .rst     (rst),
    .req     (freq),
    .f_valid (f_valid),
    .f       (f)
  );

  tfa_accum #(
    .THRUSTERS (THRUSTERS)
  ) u_accum (
    .clk  (clk),
    .rst  (rst),
    .cmd  (cmd),
    .f    (f),
    .done (acc_done),
    .sums (sums)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      k         <= '0;
      out_valid <= 1'b0;
    end else begin
      if (emit_now) begin
        out_valid <= 1'b1;
      end else if (forces.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (smp_acc) begin
            state <= ST_FORCE;
          end
        end
        ST_FORCE: begin
          if (f_valid) begin
            state <= ST_ACCUM;
          end
        end
        ST_ACCUM: begin
          if (k == LAST_AXIS) begin
            k     <= '0;
            state <= ST_DRAIN;
          end else begin
            k <= k + 1'b1;
          end
        end
        ST_DRAIN: begin
          if (acc_done) begin
            if (!last_q || slot_free) begin
              state <= ST_IDLE;
            end else begin
              state <= ST_EMIT;
            end
          end
        end
        ST_EMIT: begin
          if (slot_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
    if (smp_acc) begin
      t_q      <= samples.thruster;
      last_q   <= samples.last;
      active_q <= thr_ok;
    end
    if (emit_now) begin
      for (int i = 0; i < AXES; i++) begin
        out_q[i] <= sums[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      surge_pos_coef   <= '0;
      surge_neg_coef   <= '0;
      lateral_pos_coef <= '0;
      lateral_neg_coef <= '0;
      surge_class_mask <= '0;
      invert_mask      <= '0;
    end else if (cfg.valid) begin
      case (cfg_reg_t'(cfg.index))
        REG_SURGE_POS:   surge_pos_coef   <= $signed(cfg.data);
        REG_SURGE_NEG:   surge_neg_coef   <= $signed(cfg.data);
        REG_LATERAL_POS: lateral_pos_coef <= $signed(cfg.data);
        REG_LATERAL_NEG: lateral_neg_coef <= $signed(cfg.data);
        REG_SURGE_MASK:  surge_class_mask <= cfg.data[MASK_W-1:0];
        REG_INVERT_MASK: invert_mask      <= cfg.data[MASK_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign forces.valid = out_valid;
  assign forces.surge = out_q[AXIS_SURGE];
  assign forces.sway  = out_q[AXIS_SWAY];
  assign forces.heave = out_q[AXIS_HEAVE];
  assign forces.roll  = out_q[AXIS_ROLL];
  assign forces.pitch = out_q[AXIS_PITCH];
  assign forces.yaw   = out_q[AXIS_YAW];

  `TFA_ASSERT_IMP(a_done_in_drain, acc_done, state == ST_DRAIN, "axis pass ended outside drain")
  `TFA_ASSERT_IMP(a_force_in_wait, f_valid, state == ST_FORCE, "force ready outside force wait")
  `TFA_ASSERT_NXT(a_set_pending, cmd.clear, out_valid, "finished set left no result")
  `TFA_ASSERT_IMP(a_emit_busy, state == ST_EMIT, out_valid, "result wait with free slot")

endmodule
